@@ rtl/ssd_pkg.sv @@
// Shared types, codes and the character glyph table for the scan driver.
package ssd_pkg;

	// Input mode codes
	localparam logic [3:0] MODE_TICK        = 4'd0;
	localparam logic [3:0] MODE_SET_CHAR    = 4'd1;
	localparam logic [3:0] MODE_SET_DP      = 4'd2;
	localparam logic [3:0] MODE_CLR_DP      = 4'd3;
	localparam logic [3:0] MODE_SET_BLINK   = 4'd4;
	localparam logic [3:0] MODE_CLR_BLINK   = 4'd5;
	localparam logic [3:0] MODE_CLR_ALL_BLK = 4'd6;
	localparam logic [3:0] MODE_CLEAR       = 4'd7;
	localparam logic [3:0] MODE_SLEEP       = 4'd8;
	localparam logic [3:0] MODE_WAKE        = 4'd9;
	localparam logic [3:0] MODE_SAVE        = 4'd10;
	localparam logic [3:0] MODE_RESTORE     = 4'd11;

	// Decoded operation handed from front to back
	typedef enum logic [3:0] {
		OP_TICK,
		OP_CHAR,
		OP_DP_SET,
		OP_DP_CLR,
		OP_BLINK_SET,
		OP_BLINK_CLR,
		OP_BLINK_CLR_ALL,
		OP_CLEAR,
		OP_SLEEP,
		OP_WAKE,
		OP_SAVE,
		OP_RESTORE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] digit;
		logic [7:0] glyph;
	} cmd_t;

	typedef struct packed {
		logic [7:0] segments;
		logic [7:0] digit_strobe;
	} res_t;

	localparam logic [7:0] CHAR_FIRST = 8'h2D;
	localparam logic [7:0] CHAR_LAST  = 8'h5A;
	localparam logic [7:0] GLYPH_BLANK = 8'h7F;
	localparam int GLYPH_N = 47;

	// Entry 0 is the degree sign, entry 1 + (c - '-') serves '-'..'Z'
	localparam logic [7:0] GLYPH_ROM [GLYPH_N] = '{
		8'h1C, 8'h3F, 8'hFF, 8'hFF, 8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12,
		8'h02, 8'h78, 8'h00, 8'h10, 8'hFF, 8'hFF, 8'h27, 8'hFF, 8'h33, 8'hFF,
		8'hFF, 8'h08, 8'h03, 8'h46, 8'h21, 8'h06, 8'h0E, 8'h10, 8'h09, 8'h4F,
		8'h71, 8'hFF, 8'h47, 8'hFF, 8'h48, 8'h23, 8'h0C, 8'hFF, 8'h2F, 8'h12,
		8'h07, 8'h41, 8'hFF, 8'hFF, 8'hFF, 8'h0D, 8'hFF
	};

	function automatic logic [7:0] glyph_for(input logic [7:0] c);
		logic [7:0] offs;
		logic [7:0] g;
		offs = c - (CHAR_FIRST - 8'd1);
		if (c == 8'd0) begin
			g = GLYPH_ROM[0];
		end else if (c >= CHAR_FIRST && c <= CHAR_LAST) begin
			g = GLYPH_ROM[offs[5:0]];
		end else begin
			g = GLYPH_BLANK;
		end
		return g;
	endfunction

endpackage

@@ rtl/ssd_fifo.sv @@
// Small register queue used between the driver stages.
module ssd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

@@ rtl/ssd_front.sv @@
// Front end: accepts input beats, decodes the mode and looks up glyphs.
module ssd_front #(
	parameter int DIGITS = 6
) (
	input  logic          push,
	input  logic          full,
	input  logic [3:0]    mode,
	input  logic [2:0]    digit,
	input  logic [7:0]    char_code,
	output logic          cmd_wr,
	output ssd_pkg::cmd_t cmd
);
	import ssd_pkg::*;

	logic ok;
	logic keep;
	op_t  op;

	assign ok = ({1'b0, digit} < 4'(DIGITS));

	// Classify; drop unused modes and out-of-range digit commands
	always_comb begin
		op   = OP_TICK;
		keep = 1'b1;
		case (mode)
			MODE_TICK:        op = OP_TICK;
			MODE_SET_CHAR:    begin op = OP_CHAR;      keep = ok; end
			MODE_SET_DP:      begin op = OP_DP_SET;    keep = ok; end
			MODE_CLR_DP:      begin op = OP_DP_CLR;    keep = ok; end
			MODE_SET_BLINK:   begin op = OP_BLINK_SET; keep = ok; end
			MODE_CLR_BLINK:   begin op = OP_BLINK_CLR; keep = ok; end
			MODE_CLR_ALL_BLK: op = OP_BLINK_CLR_ALL;
			MODE_CLEAR:       op = OP_CLEAR;
			MODE_SLEEP:       op = OP_SLEEP;
			MODE_WAKE:        op = OP_WAKE;
			MODE_SAVE:        op = OP_SAVE;
			MODE_RESTORE:     op = OP_RESTORE;
			default:          keep = 1'b0;
		endcase
	end

	assign cmd_wr    = push && !full && keep;
	assign cmd.op    = op;
	assign cmd.digit = digit;
	assign cmd.glyph = glyph_for(char_code);
endmodule

@@ rtl/ssd_back.sv @@
// Back end: display state, scan counter and tick result generation.
module ssd_back #(
	parameter int DIGITS      = 6,
	parameter int FRAME_CYCLE = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  ssd_pkg::cmd_t cmd,
	output logic          cmd_rd,
	input  logic          res_full,
	output logic          res_wr,
	output ssd_pkg::res_t res
);
	import ssd_pkg::*;

	localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int PH_W  = $clog2(FRAME_CYCLE);
	localparam int HALF  = FRAME_CYCLE / 2;

	// Pattern split into segments G..A and the dp bit
	logic [6:0]        seg_q      [DIGITS];
	logic [DIGITS-1:0] dp_q;
	logic [DIGITS-1:0] blink_q;
	logic [POS_W-1:0]  pos_q;
	logic [PH_W-1:0]   phase_q;
	logic              sleep_q;
	logic [6:0]        sv_seg_q   [DIGITS];
	logic [DIGITS-1:0] sv_dp_q;
	logic [DIGITS-1:0] sv_blink_q;
	logic [POS_W-1:0]  sv_pos_q;
	logic [PH_W-1:0]   sv_phase_q;

	logic [POS_W-1:0]  idx;
	logic [7:0]        cur_seg;
	logic              blank_phase;

	assign idx = cmd.digit[POS_W-1:0];

	// Tick result for the current scan position
	always_comb begin
		blank_phase = blink_q[pos_q] && (phase_q >= PH_W'(HALF));
		cur_seg     = blank_phase ? {dp_q[pos_q], 7'h7F} : {dp_q[pos_q], seg_q[pos_q]};
		if (sleep_q) begin
			res.segments     = 8'hFF;
			res.digit_strobe = 8'hFF;
		end else begin
			res.segments     = cur_seg;
			res.digit_strobe = ~(8'd1 << pos_q);
		end
	end

	// Ticks wait for result space, commands never stall
	assign cmd_rd = cmd_valid && (cmd.op != OP_TICK || !res_full);
	assign res_wr = cmd_rd && (cmd.op == OP_TICK);

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				seg_q[i]    <= 7'h3F;
				sv_seg_q[i] <= '0;
			end
			dp_q       <= '1;
			blink_q    <= '0;
			pos_q      <= '0;
			phase_q    <= '0;
			sleep_q    <= 1'b0;
			sv_dp_q    <= '0;
			sv_blink_q <= '0;
			sv_pos_q   <= '0;
			sv_phase_q <= '0;
		end else if (cmd_rd) begin
			case (cmd.op)
				OP_TICK: begin
					if (!sleep_q) begin
						if (pos_q == POS_W'(DIGITS - 1)) begin
							pos_q   <= '0;
							phase_q <= (phase_q == PH_W'(FRAME_CYCLE - 1)) ? '0 : phase_q + 1'b1;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				OP_CHAR: begin
					seg_q[idx] <= cmd.glyph[6:0];
					if (cmd.glyph[7]) begin
						dp_q[idx] <= 1'b1;
					end
				end
				OP_DP_SET:        dp_q[idx]    <= 1'b0;
				OP_DP_CLR:        dp_q[idx]    <= 1'b1;
				OP_BLINK_SET:     blink_q[idx] <= 1'b1;
				OP_BLINK_CLR:     blink_q[idx] <= 1'b0;
				OP_BLINK_CLR_ALL: blink_q      <= '0;
				OP_CLEAR, OP_SLEEP, OP_WAKE: begin
					for (int i = 0; i < DIGITS; i++) begin
						seg_q[i] <= 7'h7F;
					end
					dp_q    <= '1;
					blink_q <= '0;
					if (cmd.op == OP_SLEEP) begin
						sleep_q <= 1'b1;
					end else if (cmd.op == OP_WAKE) begin
						sleep_q <= 1'b0;
					end
				end
				OP_SAVE: begin
					sv_seg_q   <= seg_q;
					sv_dp_q    <= dp_q;
					sv_blink_q <= blink_q;
					sv_pos_q   <= pos_q;
					sv_phase_q <= phase_q;
				end
				OP_RESTORE: begin
					seg_q   <= sv_seg_q;
					dp_q    <= sv_dp_q;
					blink_q <= sv_blink_q;
					pos_q   <= sv_pos_q;
					phase_q <= sv_phase_q;
				end
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/seven_segment_scan_driver_core.sv @@
// Top level of the multiplexed seven-segment scan driver.
// An accepted tick beat is registered in the command queue, then its result in the result queue.
// Throughput: one beat per cycle while full is low; the back end retires one command per cycle.
// A tick stalls in the command queue only while the two-entry result queue is full.
// Reset (arst_n low): digits show a dash with dp off, blink, scan, sleep and saved copies clear,
// both queues empty.
module seven_segment_scan_driver_core #(
	parameter int DIGITS      = 6,
	parameter int FRAME_CYCLE = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [3:0] mode,
	input  logic [2:0] digit,
	input  logic [7:0] char_code,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] segments,
	output logic [7:0] digit_strobe
);
	import ssd_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_wr;
	logic cmd_rd;
	logic cmd_empty;
	res_t res_in;
	res_t res_out;
	logic res_wr;
	logic res_full;

	ssd_front #(.DIGITS(DIGITS)) u_front (
		.push      (push),
		.full      (full),
		.mode      (mode),
		.digit     (digit),
		.char_code (char_code),
		.cmd_wr    (cmd_wr),
		.cmd       (cmd_in)
	);

	// Decoded command queue
	ssd_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_rd),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	ssd_back #(.DIGITS(DIGITS), .FRAME_CYCLE(FRAME_CYCLE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_rd    (cmd_rd),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res       (res_in)
	);

	// Result queue
	ssd_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign segments     = res_out.segments;
	assign digit_strobe = res_out.digit_strobe;
endmodule

@@ test/ssd_frame_checker.sv @@
// Frame checker for the seven-segment scan driver: display predictor and result compare.
`timescale 1ns / 1ps

module ssd_frame_checker #(
	parameter int DIGITS      = 6,
	parameter int FRAME_CYCLE = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [3:0] mode,
	input  logic [2:0] digit,
	input  logic [7:0] char_code,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] segments,
	input  logic [7:0] digit_strobe,
	input  logic       drained,
	output int         fail_count,
	output int         waiting
);
	import ssd_pkg::*;

	// Degree sign first, then one glyph per character from '-' to 'Z'
	localparam logic [7:0] CHAR_GLYPHS [47] = '{
		8'h1C, 8'h3F, 8'hFF, 8'hFF, 8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12,
		8'h02, 8'h78, 8'h00, 8'h10, 8'hFF, 8'hFF, 8'h27, 8'hFF, 8'h33, 8'hFF,
		8'hFF, 8'h08, 8'h03, 8'h46, 8'h21, 8'h06, 8'h0E, 8'h10, 8'h09, 8'h4F,
		8'h71, 8'hFF, 8'h47, 8'hFF, 8'h48, 8'h23, 8'h0C, 8'hFF, 8'h2F, 8'h12,
		8'h07, 8'h41, 8'hFF, 8'hFF, 8'hFF, 8'h0D, 8'hFF
	};

	// Mirror of the display memory
	logic [7:0]        pattern [DIGITS];
	logic [DIGITS-1:0] blink;
	int                scan;
	int                phase;
	logic              asleep;
	logic [7:0]        saved_pattern [DIGITS];
	logic [DIGITS-1:0] saved_blink;
	int                saved_scan;
	int                saved_phase;

	// Frames owed by ticks already accepted, oldest first
	res_t due_frames [$];
	bit   leftover_checked;

	task automatic report(input string what, input int got, input int want);
		fail_count++;
		$display("%0t ns  MISMATCH %s: got %02h want %02h", $time, what, got, want);
	endtask

	function automatic logic [7:0] char_glyph(input logic [7:0] c);
		logic [7:0] g;
		g = 8'h7F;
		if (c == 8'h00) begin
			g = CHAR_GLYPHS[0];
		end else if (c >= 8'h2D && c <= 8'h5A) begin
			g = CHAR_GLYPHS[int'(c) - 8'h2D + 1];
		end
		return g;
	endfunction

	task automatic blank_display();
		for (int i = 0; i < DIGITS; i++) begin
			pattern[i] = 8'hFF;
		end
		blink = '0;
	endtask

	// Apply one accepted beat to the mirror; a tick also queues the frame it shows
	task automatic advance_display(input logic [3:0] m, input logic [2:0] d, input logic [7:0] c);
		res_t f;
		logic hit;
		hit = int'(d) < DIGITS;
		case (m)
			MODE_TICK: begin
				f.segments     = 8'hFF;
				f.digit_strobe = 8'hFF;
				if (!asleep) begin
					if (scan < DIGITS) begin
						f.segments = pattern[scan];
						// upper half of the frame cycle: blinking digit keeps only its dp
						if (blink[scan] && phase >= FRAME_CYCLE / 2) begin
							f.segments = {pattern[scan][7], 7'h7F};
						end
						f.digit_strobe = ~(8'd1 << scan);
					end
					scan++;
					if (scan >= DIGITS) begin
						scan  = 0;
						phase = (phase + 1) % FRAME_CYCLE;
					end
				end
				due_frames.push_back(f);
			end
			MODE_SET_CHAR: begin
				if (hit) pattern[d] = {pattern[d][7], 7'h00} | char_glyph(c);
			end
			MODE_SET_DP: begin
				if (hit) pattern[d][7] = 1'b0;
			end
			MODE_CLR_DP: begin
				if (hit) pattern[d][7] = 1'b1;
			end
			MODE_SET_BLINK: begin
				if (hit) blink[d] = 1'b1;
			end
			MODE_CLR_BLINK: begin
				if (hit) blink[d] = 1'b0;
			end
			MODE_CLR_ALL_BLK: begin
				blink = '0;
			end
			MODE_CLEAR: begin
				blank_display();
			end
			MODE_SLEEP: begin
				blank_display();
				asleep = 1'b1;
			end
			MODE_WAKE: begin
				blank_display();
				asleep = 1'b0;
			end
			MODE_SAVE: begin
				saved_pattern = pattern;
				saved_blink   = blink;
				saved_scan    = scan;
				saved_phase   = phase;
			end
			MODE_RESTORE: begin
				pattern = saved_pattern;
				blink   = saved_blink;
				scan    = saved_scan;
				phase   = saved_phase;
			end
			default: begin
			end
		endcase
	endtask

	// Watch both channels; input beats are predicted before the output beat is checked
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				pattern[i]       = 8'hBF;
				saved_pattern[i] = 8'h00;
			end
			blink            = '0;
			scan             = 0;
			phase            = 0;
			asleep           = 1'b0;
			saved_blink      = '0;
			saved_scan       = 0;
			saved_phase      = 0;
			fail_count       = 0;
			leftover_checked = 1'b0;
			due_frames.delete();
			waiting <= 0;
		end else begin
			if (push && !full) begin
				advance_display(mode, digit, char_code);
			end
			if (pop && !empty) begin
				if (due_frames.size() == 0) begin
					report("frame with no tick pending", int'(segments), 255);
				end else begin
					want = due_frames.pop_front();
					if (segments !== want.segments) begin
						report("segments", int'(segments), int'(want.segments));
					end
					if (digit_strobe !== want.digit_strobe) begin
						report("digit_strobe", int'(digit_strobe), int'(want.digit_strobe));
					end
				end
			end
			if (drained && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (due_frames.size() != 0) begin
					report("frames never delivered", due_frames.size(), 0);
				end
			end
			waiting <= due_frames.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// Testbench top for the seven-segment scan driver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import ssd_pkg::*;

	localparam int DIGITS      = 6;
	localparam int FRAME_CYCLE = 32;
	localparam int BEAT_GOAL   = 1100;
	localparam int FLOOD_AT    = 400;
	localparam int PAUSE_AT    = 800;
	localparam int HOLD_CYCLES = 150;

	// A mode code with no command behind it
	localparam logic [3:0] MODE_UNUSED = 4'd15;

	// Directed beats: {mode, digit, char_code}
	localparam logic [14:0] DIRECTED [25] = '{
		{MODE_TICK,        3'd0, 8'h00},
		{MODE_SET_CHAR,    3'd0, 8'h00},
		{MODE_SET_CHAR,    3'd1, 8'h2D},
		{MODE_SET_CHAR,    3'd2, 8'h5A},
		{MODE_SET_CHAR,    3'd3, 8'h2C},
		{MODE_SET_CHAR,    3'd5, 8'hFF},
		{MODE_SET_DP,      3'd0, 8'h00},
		{MODE_SET_CHAR,    3'd0, 8'h41},
		{MODE_SET_CHAR,    3'd6, 8'h41},
		{MODE_SET_DP,      3'd7, 8'h00},
		{MODE_SET_BLINK,   3'd1, 8'h00},
		{MODE_SAVE,        3'd0, 8'h00},
		{MODE_TICK,        3'd0, 8'h00},
		{MODE_TICK,        3'd0, 8'h00},
		{MODE_CLR_DP,      3'd0, 8'h00},
		{MODE_CLR_BLINK,   3'd1, 8'h00},
		{MODE_CLR_ALL_BLK, 3'd0, 8'h00},
		{MODE_UNUSED,      3'd7, 8'h80},
		{MODE_SLEEP,       3'd0, 8'h00},
		{MODE_TICK,        3'd0, 8'h00},
		{MODE_WAKE,        3'd0, 8'h00},
		{MODE_RESTORE,     3'd0, 8'h00},
		{MODE_TICK,        3'd0, 8'h00},
		{MODE_CLEAR,       3'd0, 8'h00},
		{MODE_TICK,        3'd0, 8'h00}
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic       full;
	logic [3:0] mode      = MODE_TICK;
	logic [2:0] digit     = 3'd0;
	logic [7:0] char_code = 8'h00;
	logic       empty;
	logic       pop       = 1'b0;
	logic [7:0] segments;
	logic [7:0] digit_strobe;
	logic       drained   = 1'b0;
	int         fail_count;
	int         waiting;

	int         sent       = 0;
	int         burst_left = 1;
	bit         steady     = 1'b0;
	bit         flooded    = 1'b0;
	bit         paused     = 1'b0;
	int         pop_cycle  = 0;
	bit         held       = 1'b0;

	seven_segment_scan_driver_core #(
		.DIGITS      (DIGITS),
		.FRAME_CYCLE (FRAME_CYCLE)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.digit        (digit),
		.char_code    (char_code),
		.empty        (empty),
		.pop          (pop),
		.segments     (segments),
		.digit_strobe (digit_strobe)
	);

	ssd_frame_checker #(
		.DIGITS      (DIGITS),
		.FRAME_CYCLE (FRAME_CYCLE)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.digit        (digit),
		.char_code    (char_code),
		.empty        (empty),
		.pop          (pop),
		.segments     (segments),
		.digit_strobe (digit_strobe),
		.drained      (drained),
		.fail_count   (fail_count),
		.waiting      (waiting)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop in case a beat never completes
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Hold one beat on the input until the block takes it
	task automatic offer(input logic [3:0] m, input logic [2:0] d, input logic [7:0] c);
		push      <= 1'b1;
		mode      <= m;
		digit     <= d;
		char_code <= c;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Send a beat as part of a burst; between bursts the input may go quiet for a while, but never in steady mode
	task automatic put_beat(input logic [3:0] m, input logic [2:0] d, input logic [7:0] c);
		int gap;
		offer(m, d, c);
		sent <= sent + 1;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = int'($urandom_range(1, 24));
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 10));
			if (gap > 0 && !steady) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = int'($urandom_range(0, 9));
		if (r < 6) return 8'($urandom_range(8'h2D, 8'h5A));
		if (r == 6) return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [2:0] pick_digit();
		return ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
	endfunction

	// Mostly well-formed use: fill the digits, decorate some, then scan for a while
	task automatic play_frame();
		if ($urandom_range(0, 4) == 0) put_beat(MODE_WAKE, pick_digit(), 8'h00);
		for (int i = 0; i < DIGITS; i++) begin
			put_beat(MODE_SET_CHAR, 3'(i), pick_char());
		end
		if ($urandom_range(0, 9) < 4) put_beat(MODE_SET_DP, pick_digit(), pick_char());
		if ($urandom_range(0, 9) < 3) put_beat(MODE_CLR_DP, pick_digit(), pick_char());
		if ($urandom_range(0, 9) < 4) put_beat(MODE_SET_BLINK, pick_digit(), pick_char());
		if ($urandom_range(0, 9) < 2) put_beat(MODE_CLR_BLINK, pick_digit(), pick_char());
		if ($urandom_range(0, 19) == 0) put_beat(MODE_CLR_ALL_BLK, 3'd0, 8'h00);
		if ($urandom_range(0, 9) == 0) put_beat(MODE_SAVE, 3'd0, 8'h00);
		if ($urandom_range(0, 14) == 0) put_beat(MODE_RESTORE, 3'd0, 8'h00);
		repeat ($urandom_range(6, 40)) put_beat(MODE_TICK, pick_digit(), pick_char());
	endtask

	// Receiver: own stall pattern, plus one long hold-off once the flood starts
	initial begin
		forever begin
			@(posedge clk);
			pop_cycle++;
			if (!held && sent >= FLOOD_AT) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case ((pop_cycle / 97) % 4)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= (pop_cycle % 5 == 0);
					default: pop <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 25; i++) begin
			put_beat(DIRECTED[i][14:11], DIRECTED[i][10:8], DIRECTED[i][7:0]);
		end

		while (sent < BEAT_GOAL) begin
			// back-to-back ticks while the receiver holds off, to fill the block
			if (!flooded && sent >= FLOOD_AT) begin
				flooded = 1'b1;
				steady  = 1'b1;
				repeat (80) put_beat(MODE_TICK, 3'd0, 8'h00);
				steady  = 1'b0;
			end
			// let the block drain completely once
			if (!paused && sent >= PAUSE_AT) begin
				paused = 1'b1;
				push <= 1'b0;
				@(posedge clk);
				while (waiting != 0) @(posedge clk);
			end
			if ($urandom_range(0, 9) < 7) begin
				play_frame();
			end else begin
				repeat ($urandom_range(1, 4)) begin
					put_beat(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
						8'($urandom_range(0, 255)));
				end
			end
		end

		push <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		drained <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
